### design/frh_pkg.sv
package frh_pkg;

  localparam int unsigned IdW       = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned PwmW      = 16;
  localparam int unsigned CountW    = 32;
  localparam int unsigned StopMaxW  = 8;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned StatusW   = 3;

  localparam logic [StopMaxW-1:0]  StopSendMaxRst    = 8'd3;
  localparam logic [IntervalW-1:0] StopIntervalRst   = 16'd100;
  localparam logic [IdW-1:0]       FirstId           = 16'd1;
  localparam logic [StatusW-1:0]   StatusArmedOffset = 3'd3;

  typedef enum logic [2:0] {
    FUNC_REQUEST = 3'd0,
    FUNC_ACK     = 3'd1,
    FUNC_REPORT  = 3'd2,
    FUNC_ARM     = 3'd3,
    FUNC_CANCEL  = 3'd4,
    FUNC_TICK    = 3'd5,
    FUNC_RESTART = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACK    = 2'd1,
    PH_REPORT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    REG_STOP_LIMIT       = 1'b0,
    REG_STOP_INTERVAL_MS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]              func;
    logic [TimeW-1:0]        now_ms;
    logic [IdW-1:0]          msg_frame_id;
    logic                    reset_pi;
    logic                    external_ready;
    logic signed [SpeedW-1:0] left_value;
    logic signed [SpeedW-1:0] right_value;
    logic signed [PwmW-1:0]   left_pwm_in;
    logic signed [PwmW-1:0]   right_pwm_in;
    logic signed [CountW-1:0] left_count_in;
    logic signed [CountW-1:0] right_count_in;
  } item_t;

  typedef struct packed {
    logic                     accepted;
    logic [1:0]               cmd_kind;
    logic [IdW-1:0]           cmd_frame_id;
    logic signed [SpeedW-1:0] cmd_left_setpoint;
    logic signed [SpeedW-1:0] cmd_right_setpoint;
    logic [StatusW-1:0]       status;
    logic signed [SpeedW-1:0] left_speed;
    logic signed [SpeedW-1:0] right_speed;
    logic signed [PwmW-1:0]   left_pwm;
    logic signed [PwmW-1:0]   right_pwm;
    logic signed [CountW-1:0] left_count;
    logic signed [CountW-1:0] right_count;
  } result_t;

  typedef struct packed {
    logic [StopMaxW-1:0]  stop_limit;
    logic [IntervalW-1:0] stop_interval_ms;
  } cfg_t;

endpackage

### design/frh_ctrl.sv
module frh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  frh_pkg::item_t  item,
  input  frh_pkg::cfg_t   cfg,
  output frh_pkg::result_t res
);
  import frh_pkg::*;

  logic [IdW-1:0]           next_id_r, next_id_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [IdW-1:0]           pending_id_r, pending_id_nxt;
  logic                     snap_valid_r, snap_valid_nxt;
  logic [TimeW-1:0]         last_send_r, last_send_nxt;
  logic [StopMaxW-1:0]      stop_sent_r, stop_sent_nxt;
  logic                     stop_on_r, stop_on_nxt;
  logic signed [SpeedW-1:0] speed_l_r, speed_l_nxt, speed_r_r, speed_r_nxt;
  logic signed [PwmW-1:0]   pwm_l_r, pwm_l_nxt, pwm_r_r, pwm_r_nxt;
  logic signed [CountW-1:0] cnt_l_r, cnt_l_nxt, cnt_r_r, cnt_r_nxt;

  logic [IdW-1:0]   id_inc;
  logic [IdW-1:0]   id_after;
  logic [TimeW-1:0] elapsed;
  logic             interval_ok;
  logic             id_match;
  logic [StopMaxW-1:0] sent_inc;

  assign id_inc      = next_id_r + IdW'(1);
  assign id_after    = (id_inc == '0) ? FirstId : id_inc;
  assign elapsed     = item.now_ms - last_send_r;
  assign interval_ok = elapsed >= TimeW'(cfg.stop_interval_ms);
  assign id_match    = snap_valid_r && (item.msg_frame_id == pending_id_r);
  assign sent_inc    = stop_sent_r + StopMaxW'(1);

  always_comb begin
    next_id_nxt    = next_id_r;
    phase_nxt      = phase_r;
    pending_id_nxt = pending_id_r;
    snap_valid_nxt = snap_valid_r;
    last_send_nxt  = last_send_r;
    stop_sent_nxt  = stop_sent_r;
    stop_on_nxt    = stop_on_r;
    speed_l_nxt    = speed_l_r;
    speed_r_nxt    = speed_r_r;
    pwm_l_nxt      = pwm_l_r;
    pwm_r_nxt      = pwm_r_r;
    cnt_l_nxt      = cnt_l_r;
    cnt_r_nxt      = cnt_r_r;
    res            = '0;

    case (func_t'(item.func))
      FUNC_REQUEST: begin
        if (phase_r == PH_IDLE) begin
          next_id_nxt           = id_after;
          pending_id_nxt        = next_id_r;
          snap_valid_nxt        = 1'b1;
          phase_nxt             = PH_ACK;
          last_send_nxt         = item.now_ms;
          res.cmd_kind          = item.reset_pi ? CMD_RESET : CMD_SEND;
          res.cmd_frame_id      = next_id_r;
          res.cmd_left_setpoint = item.left_value;
          res.cmd_right_setpoint = item.right_value;
          res.accepted          = 1'b1;
        end
      end
      FUNC_ACK: begin
        if (phase_r == PH_ACK && id_match) begin
          phase_nxt    = PH_REPORT;
          res.accepted = 1'b1;
        end
      end
      FUNC_REPORT: begin
        if (phase_r == PH_REPORT && id_match) begin
          speed_l_nxt    = item.left_value;
          speed_r_nxt    = item.right_value;
          pwm_l_nxt      = item.left_pwm_in;
          pwm_r_nxt      = item.right_pwm_in;
          cnt_l_nxt      = item.left_count_in;
          cnt_r_nxt      = item.right_count_in;
          phase_nxt      = PH_IDLE;
          snap_valid_nxt = 1'b0;
          res.accepted   = 1'b1;
        end
      end
      FUNC_ARM: begin
        stop_on_nxt   = 1'b1;
        stop_sent_nxt = '0;
      end
      FUNC_CANCEL: begin
        stop_on_nxt   = 1'b0;
        stop_sent_nxt = '0;
      end
      FUNC_TICK: begin
        if (stop_on_r && item.external_ready && phase_r == PH_IDLE) begin
          if (stop_sent_r >= cfg.stop_limit) begin
            stop_on_nxt   = 1'b0;
            stop_sent_nxt = '0;
          end else if (stop_sent_r == '0 || interval_ok) begin
            next_id_nxt      = id_after;
            last_send_nxt    = item.now_ms;
            res.cmd_kind     = CMD_SEND;
            res.cmd_frame_id = next_id_r;
            res.accepted     = 1'b1;
            stop_sent_nxt    = sent_inc;
            if (sent_inc >= cfg.stop_limit) begin
              stop_on_nxt = 1'b0;
            end
          end
        end
      end
      FUNC_RESTART: begin
        next_id_nxt    = FirstId;
        phase_nxt      = PH_IDLE;
        pending_id_nxt = '0;
        snap_valid_nxt = 1'b0;
        last_send_nxt  = '0;
        stop_sent_nxt  = '0;
        stop_on_nxt    = 1'b0;
        speed_l_nxt    = '0;
        speed_r_nxt    = '0;
        pwm_l_nxt      = '0;
        pwm_r_nxt      = '0;
        cnt_l_nxt      = '0;
        cnt_r_nxt      = '0;
      end
      default: begin
      end
    endcase

    res.status      = StatusW'(phase_nxt) + (stop_on_nxt ? StatusArmedOffset : '0);
    res.left_speed  = speed_l_nxt;
    res.right_speed = speed_r_nxt;
    res.left_pwm    = pwm_l_nxt;
    res.right_pwm   = pwm_r_nxt;
    res.left_count  = cnt_l_nxt;
    res.right_count = cnt_r_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r    <= FirstId;
      phase_r      <= PH_IDLE;
      pending_id_r <= '0;
      snap_valid_r <= 1'b0;
      last_send_r  <= '0;
      stop_sent_r  <= '0;
      stop_on_r    <= 1'b0;
      speed_l_r    <= '0;
      speed_r_r    <= '0;
      pwm_l_r      <= '0;
      pwm_r_r      <= '0;
      cnt_l_r      <= '0;
      cnt_r_r      <= '0;
    end else if (take) begin
      next_id_r    <= next_id_nxt;
      phase_r      <= phase_nxt;
      pending_id_r <= pending_id_nxt;
      snap_valid_r <= snap_valid_nxt;
      last_send_r  <= last_send_nxt;
      stop_sent_r  <= stop_sent_nxt;
      stop_on_r    <= stop_on_nxt;
      speed_l_r    <= speed_l_nxt;
      speed_r_r    <= speed_r_nxt;
      pwm_l_r      <= pwm_l_nxt;
      pwm_r_r      <= pwm_r_nxt;
      cnt_l_r      <= cnt_l_nxt;
      cnt_r_r      <= cnt_r_nxt;
    end
  end

endmodule

### design/frame_request_handshake.sv
// frame_request_handshake: frame id request/ack/report controller with stop sequence.
// The result of an item is registered and valid the cycle after it is accepted.
// Throughput: 1 item per cycle while out_ready is high; the controller state updates in the accept
// cycle and the single output register takes the result while the previous one drains.
// Reset (rst_n, synchronous, active low): state cleared, next frame id 1,
// stop limit 3, stop_interval_ms 100, output register empty.
module frame_request_handshake (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_func,
  input  logic [frh_pkg::TimeW-1:0]          in_now_ms,
  input  logic [frh_pkg::IdW-1:0]            in_msg_frame_id,
  input  logic                               in_reset_pi,
  input  logic                               in_external_ready,
  input  logic signed [frh_pkg::SpeedW-1:0]  in_left_value,
  input  logic signed [frh_pkg::SpeedW-1:0]  in_right_value,
  input  logic signed [frh_pkg::PwmW-1:0]    in_left_pwm_in,
  input  logic signed [frh_pkg::PwmW-1:0]    in_right_pwm_in,
  input  logic signed [frh_pkg::CountW-1:0]  in_left_count_in,
  input  logic signed [frh_pkg::CountW-1:0]  in_right_count_in,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [1:0]                         out_cmd_kind,
  output logic [frh_pkg::IdW-1:0]            out_cmd_frame_id,
  output logic signed [frh_pkg::SpeedW-1:0]  out_cmd_left_setpoint,
  output logic signed [frh_pkg::SpeedW-1:0]  out_cmd_right_setpoint,
  output logic [frh_pkg::StatusW-1:0]        out_status,
  output logic signed [frh_pkg::SpeedW-1:0]  out_left_speed,
  output logic signed [frh_pkg::SpeedW-1:0]  out_right_speed,
  output logic signed [frh_pkg::PwmW-1:0]    out_left_pwm,
  output logic signed [frh_pkg::PwmW-1:0]    out_right_pwm,
  output logic signed [frh_pkg::CountW-1:0]  out_left_count,
  output logic signed [frh_pkg::CountW-1:0]  out_right_count,

  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [frh_pkg::CfgDataW-1:0]       cfg_wdata
);
  import frh_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    take;

  // Accept a new item whenever the output register is empty or drains this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // Bundle the item fields for the controller.
  assign item.func           = in_func;
  assign item.now_ms         = in_now_ms;
  assign item.msg_frame_id   = in_msg_frame_id;
  assign item.reset_pi       = in_reset_pi;
  assign item.external_ready = in_external_ready;
  assign item.left_value     = in_left_value;
  assign item.right_value    = in_right_value;
  assign item.left_pwm_in    = in_left_pwm_in;
  assign item.right_pwm_in   = in_right_pwm_in;
  assign item.left_count_in  = in_left_count_in;
  assign item.right_count_in = in_right_count_in;

  // Configuration registers, write only: the user must write while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_limit       <= StopSendMaxRst;
      cfg_r.stop_interval_ms <= StopIntervalRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STOP_LIMIT:       cfg_r.stop_limit       <= cfg_wdata[StopMaxW-1:0];
        REG_STOP_INTERVAL_MS: cfg_r.stop_interval_ms <= cfg_wdata[IntervalW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller: state registers plus the single-pass update for one item.
  frh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register: load on accept, drop valid once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_accepted           = res_r.accepted;
  assign out_cmd_kind           = res_r.cmd_kind;
  assign out_cmd_frame_id       = res_r.cmd_frame_id;
  assign out_cmd_left_setpoint  = res_r.cmd_left_setpoint;
  assign out_cmd_right_setpoint = res_r.cmd_right_setpoint;
  assign out_status             = res_r.status;
  assign out_left_speed         = res_r.left_speed;
  assign out_right_speed        = res_r.right_speed;
  assign out_left_pwm           = res_r.left_pwm;
  assign out_right_pwm          = res_r.right_pwm;
  assign out_left_count         = res_r.left_count;
  assign out_right_count        = res_r.right_count;

endmodule

### tb/tb.sv
module tb;
  import frh_pkg::*;

  // func code 7 has no meaning; the block must ignore it
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  // generous bound for about 1300 items with the longest idle gaps
  localparam int CYCLE_LIMIT = 100000;

  // how the driver fills in msg_frame_id when the item goes out
  typedef enum logic [1:0] {
    ID_RAW,    // keep the random id drawn at generation
    ID_MATCH,  // use the id the link is waiting on right now
    ID_NEAR    // the waited-on id with one bit flipped
  } id_mode_t;

  typedef struct {
    item_t    it;
    id_mode_t mode;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_func = FUNC_REQUEST;
  logic [TimeW-1:0]         in_now_ms = '0;
  logic [IdW-1:0]           in_msg_frame_id = '0;
  logic                     in_reset_pi = 1'b0;
  logic                     in_external_ready = 1'b0;
  logic signed [SpeedW-1:0] in_left_value = '0;
  logic signed [SpeedW-1:0] in_right_value = '0;
  logic signed [PwmW-1:0]   in_left_pwm_in = '0;
  logic signed [PwmW-1:0]   in_right_pwm_in = '0;
  logic signed [CountW-1:0] in_left_count_in = '0;
  logic signed [CountW-1:0] in_right_count_in = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_accepted;
  logic [1:0]               out_cmd_kind;
  logic [IdW-1:0]           out_cmd_frame_id;
  logic signed [SpeedW-1:0] out_cmd_left_setpoint;
  logic signed [SpeedW-1:0] out_cmd_right_setpoint;
  logic [StatusW-1:0]       out_status;
  logic signed [SpeedW-1:0] out_left_speed;
  logic signed [SpeedW-1:0] out_right_speed;
  logic signed [PwmW-1:0]   out_left_pwm;
  logic signed [PwmW-1:0]   out_right_pwm;
  logic signed [CountW-1:0] out_left_count;
  logic signed [CountW-1:0] out_right_count;

  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_STOP_LIMIT;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  frame_request_handshake uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_func               (in_func),
    .in_now_ms             (in_now_ms),
    .in_msg_frame_id       (in_msg_frame_id),
    .in_reset_pi           (in_reset_pi),
    .in_external_ready     (in_external_ready),
    .in_left_value         (in_left_value),
    .in_right_value        (in_right_value),
    .in_left_pwm_in        (in_left_pwm_in),
    .in_right_pwm_in       (in_right_pwm_in),
    .in_left_count_in      (in_left_count_in),
    .in_right_count_in     (in_right_count_in),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_accepted          (out_accepted),
    .out_cmd_kind          (out_cmd_kind),
    .out_cmd_frame_id      (out_cmd_frame_id),
    .out_cmd_left_setpoint (out_cmd_left_setpoint),
    .out_cmd_right_setpoint(out_cmd_right_setpoint),
    .out_status            (out_status),
    .out_left_speed        (out_left_speed),
    .out_right_speed       (out_right_speed),
    .out_left_pwm          (out_left_pwm),
    .out_right_pwm         (out_right_pwm),
    .out_left_count        (out_left_count),
    .out_right_count       (out_right_count),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Link predictor: our own copy of the controller state and its registers.
  // The request timestamp is kept as well: it never reaches an output, but it times the stops.
  // ---------------------------------------------------------------------------
  logic [StopMaxW-1:0]  reg_stop_max;
  logic [IntervalW-1:0] reg_interval;

  logic [IdW-1:0]    lk_next_id;
  phase_t            lk_phase;
  logic [IdW-1:0]    lk_pending;
  logic              lk_snap;
  logic [TimeW-1:0]  lk_last_send;
  logic [StopMaxW-1:0] lk_stops;
  logic              lk_armed;
  logic [SpeedW-1:0] lk_speed [2];
  logic [PwmW-1:0]   lk_pwm [2];
  logic [CountW-1:0] lk_count [2];

  function automatic void wipe_link();
    lk_next_id   = FirstId;
    lk_phase     = PH_IDLE;
    lk_pending   = '0;
    lk_snap      = 1'b0;
    lk_last_send = '0;
    lk_stops     = '0;
    lk_armed     = 1'b0;
    for (int i = 0; i < 2; i++) begin
      lk_speed[i] = '0;
      lk_pwm[i]   = '0;
      lk_count[i] = '0;
    end
  endfunction

  // hand out the next frame id, skipping 0 on wrap
  function automatic logic [IdW-1:0] grab_id();
    logic [IdW-1:0] id;
    id = lk_next_id;
    lk_next_id = lk_next_id + 1'b1;
    if (lk_next_id == '0) lk_next_id = FirstId;
    return id;
  endfunction

  function automatic result_t advance_link(item_t it);
    result_t r;
    r = '0;
    case (it.func)
      FUNC_REQUEST: begin
        if (lk_phase == PH_IDLE) begin
          r.cmd_frame_id       = grab_id();
          lk_pending           = r.cmd_frame_id;
          lk_snap              = 1'b1;
          lk_phase             = PH_ACK;
          lk_last_send         = it.now_ms;
          r.cmd_kind           = it.reset_pi ? CMD_RESET : CMD_SEND;
          r.cmd_left_setpoint  = it.left_value;
          r.cmd_right_setpoint = it.right_value;
          r.accepted           = 1'b1;
        end
      end
      FUNC_ACK: begin
        if (lk_phase == PH_ACK && lk_snap && it.msg_frame_id == lk_pending) begin
          lk_phase   = PH_REPORT;
          r.accepted = 1'b1;
        end
      end
      FUNC_REPORT: begin
        if (lk_phase == PH_REPORT && lk_snap && it.msg_frame_id == lk_pending) begin
          lk_speed[0] = it.left_value;
          lk_speed[1] = it.right_value;
          lk_pwm[0]   = it.left_pwm_in;
          lk_pwm[1]   = it.right_pwm_in;
          lk_count[0] = it.left_count_in;
          lk_count[1] = it.right_count_in;
          lk_phase    = PH_IDLE;
          lk_snap     = 1'b0;
          r.accepted  = 1'b1;
        end
      end
      FUNC_ARM: begin
        lk_armed = 1'b1;
        lk_stops = '0;
      end
      FUNC_CANCEL: begin
        lk_armed = 1'b0;
        lk_stops = '0;
      end
      FUNC_TICK: begin
        if (lk_armed && it.external_ready && lk_phase == PH_IDLE) begin
          if (lk_stops >= reg_stop_max) begin
            // count already reached: disarm quietly
            lk_armed = 1'b0;
            lk_stops = '0;
          end else if (lk_stops == '0 ||
                       (it.now_ms - lk_last_send) >= TimeW'(reg_interval)) begin
            r.cmd_frame_id = grab_id();
            lk_last_send   = it.now_ms;
            r.cmd_kind     = CMD_SEND;
            r.accepted     = 1'b1;
            lk_stops       = lk_stops + 1'b1;
            if (lk_stops >= reg_stop_max) lk_armed = 1'b0;
          end
        end
      end
      FUNC_RESTART: wipe_link();
      default: ;
    endcase
    r.status      = StatusW'(lk_phase) + (lk_armed ? StatusArmedOffset : '0);
    r.left_speed  = lk_speed[0];
    r.right_speed = lk_speed[1];
    r.left_pwm    = lk_pwm[0];
    r.right_pwm   = lk_pwm[1];
    r.left_count  = lk_count[0];
    r.right_count = lk_count[1];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  stim_t   item_q[$];     // items waiting to go out
  result_t reply_q[$];    // predicted results, oldest first
  item_t   shown;         // item currently on the input port, as driven
  stim_t   next_stim;
  bit      slot_free = 1'b1;
  int      send_gap = 0;
  int      take_gap = 0;
  bit      idle_on = 1'b1;
  int      bad_count = 0;
  int      cycle_cnt = 0;
  logic [TimeW-1:0] gen_now = '0;

  // ---------------------------------------------------------------------------
  // Driver: present the next item at the falling edge once the previous one
  // was taken and its idle gap has run out. Hold valid and payload otherwise.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (slot_free) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        next_stim = item_q.pop_front();
        shown = next_stim.it;
        // resolve ids against the link state as it stands now; every earlier
        // item has already been taken, so the predictor is current
        case (next_stim.mode)
          ID_MATCH: shown.msg_frame_id = lk_pending;
          ID_NEAR:  shown.msg_frame_id = lk_pending ^ (16'd1 << $urandom_range(0, 15));
          default: ;
        endcase
        in_func           <= shown.func;
        in_now_ms         <= shown.now_ms;
        in_msg_frame_id   <= shown.msg_frame_id;
        in_reset_pi       <= shown.reset_pi;
        in_external_ready <= shown.external_ready;
        in_left_value     <= shown.left_value;
        in_right_value    <= shown.right_value;
        in_left_pwm_in    <= shown.left_pwm_in;
        in_right_pwm_in   <= shown.right_pwm_in;
        in_left_count_in  <= shown.left_count_in;
        in_right_count_in <= shown.right_count_in;
        in_valid          <= 1'b1;
        slot_free = 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure: drop ready for the drawn number of cycles.
  always @(negedge clk) begin
    if (take_gap > 0) begin
      take_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and predictor hook, both at the rising edge. Check results first,
  // then predict the item taken at this edge, so queue order is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("result arrived with nothing expected");
        end else begin
          result_t want;
          want = reply_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_accepted));
          check_field("cmd_kind", 32'(want.cmd_kind), 32'(out_cmd_kind));
          check_field("cmd_frame_id", 32'(want.cmd_frame_id), 32'(out_cmd_frame_id));
          check_field("cmd_left_setpoint", 32'(want.cmd_left_setpoint),
                      32'(out_cmd_left_setpoint));
          check_field("cmd_right_setpoint", 32'(want.cmd_right_setpoint),
                      32'(out_cmd_right_setpoint));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("left_speed", 32'(want.left_speed), 32'(out_left_speed));
          check_field("right_speed", 32'(want.right_speed), 32'(out_right_speed));
          check_field("left_pwm", 32'(want.left_pwm), 32'(out_left_pwm));
          check_field("right_pwm", 32'(want.right_pwm), 32'(out_right_pwm));
          check_field("left_count", want.left_count, out_left_count);
          check_field("right_count", want.right_count, out_right_count);
        end
        take_gap = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (in_valid && in_ready) begin
        reply_q.push_back(advance_link(shown));
        slot_free = 1'b1;
        send_gap = idle_on ? $urandom_range(0, 7) : 0;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one item at the current generator time. pat 1 drives the payload to
  // max/min (and asks a controller reset), pat 2 to min/max, pat 0 random.
  task automatic put(input logic [2:0] f, input id_mode_t mode, input logic rdy,
                     input int pat);
    stim_t s;
    s.mode              = mode;
    s.it.func           = f;
    s.it.now_ms         = gen_now;
    s.it.msg_frame_id   = IdW'($urandom);
    s.it.reset_pi       = 1'($urandom);
    s.it.external_ready = rdy;
    s.it.left_value     = SpeedW'($urandom);
    s.it.right_value    = SpeedW'($urandom);
    s.it.left_pwm_in    = PwmW'($urandom);
    s.it.right_pwm_in   = PwmW'($urandom);
    s.it.left_count_in  = $urandom;
    s.it.right_count_in = $urandom;
    if (pat == 1) begin
      s.it.reset_pi       = 1'b1;
      s.it.left_value     = 16'sh7fff;
      s.it.right_value    = 16'sh8000;
      s.it.left_pwm_in    = 16'sh7fff;
      s.it.right_pwm_in   = 16'sh8000;
      s.it.left_count_in  = 32'sh7fffffff;
      s.it.right_count_in = 32'sh80000000;
    end else if (pat == 2) begin
      s.it.reset_pi       = 1'b0;
      s.it.left_value     = 16'sh8000;
      s.it.right_value    = 16'sh7fff;
      s.it.left_pwm_in    = 16'sh8000;
      s.it.right_pwm_in   = 16'sh7fff;
      s.it.left_count_in  = 32'sh80000000;
      s.it.right_count_in = 32'sh7fffffff;
    end
    item_q.push_back(s);
  endtask

  // Advance the generator clock: mostly short steps around the interval,
  // now and then a jump anywhere, which also walks through the wrap.
  task automatic step_clock();
    if ($urandom_range(0, 15) == 0) gen_now = gen_now + $urandom;
    else gen_now = gen_now + $urandom_range(0, 160);
  endtask

  // Any func code, any id handling: the junk between real exchanges.
  task automatic put_noise(input bit allow_restart);
    logic [2:0] f;
    id_mode_t mode;
    f = 3'($urandom_range(0, 7));
    if (f == FUNC_RESTART && !(allow_restart && $urandom_range(0, 15) == 0))
      f = FUNC_TICK;
    mode = id_mode_t'($urandom_range(0, 2));
    step_clock();
    put(f, mode, $urandom_range(0, 3) != 0, 0);
  endtask

  // Mostly complete request/ack/report exchanges and stop sequences with
  // random content; the rest is noise and broken exchanges.
  task automatic random_chunk(input int n, input bit allow_restart);
    int made;
    int pick;
    int hi;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        step_clock();
        put(FUNC_REQUEST, ID_RAW, 1'($urandom), 0);
        made++;
        if ($urandom_range(0, 2) == 0) begin
          put_noise(allow_restart);
          made++;
        end
        if ($urandom_range(0, 7) == 0) begin
          put(FUNC_ACK, ID_NEAR, 1'($urandom), 0);
          made++;
        end
        put(FUNC_ACK, ID_MATCH, 1'($urandom), 0);
        made++;
        if ($urandom_range(0, 3) == 0) begin
          put_noise(allow_restart);
          made++;
        end
        put(FUNC_REPORT, ($urandom_range(0, 7) == 0) ? ID_NEAR : ID_MATCH,
            1'($urandom), 0);
        made++;
      end else if (pick < 8) begin
        put(FUNC_ARM, ID_RAW, 1'($urandom), 0);
        made++;
        hi = (reg_stop_max > 6) ? 8 : int'(reg_stop_max) + 2;
        repeat ($urandom_range(1, hi)) begin
          step_clock();
          if ($urandom_range(0, 11) == 0) put(FUNC_CANCEL, ID_RAW, 1'($urandom), 0);
          else put(FUNC_TICK, ID_RAW, $urandom_range(0, 7) != 0, 0);
          made++;
        end
      end else begin
        put_noise(allow_restart);
        made++;
      end
    end
  endtask

  // Block until nothing is queued, in flight or outstanding. Doing this between
  // chunks is also the sender pause: no new item until every result is back.
  task automatic drain();
    while (item_q.size() != 0 || !slot_free || reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STOP_LIMIT) reg_stop_max = val[StopMaxW-1:0];
    else reg_interval = val;
  endtask

  // Junk in the upper byte of the count write must be dropped.
  task automatic set_regs(input logic [StopMaxW-1:0] max_stops,
                          input logic [IntervalW-1:0] interval);
    write_reg(REG_STOP_LIMIT, {8'($urandom), max_stops});
    write_reg(REG_STOP_INTERVAL_MS, interval);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reg_stop_max = StopSendMaxRst;
    reg_interval = StopIntervalRst;
    wipe_link();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset register values (3 stops, 100 ms apart).
    gen_now = 32'd1000;
    put(FUNC_REPORT, ID_MATCH, 1'b0, 1);   // report while idle: drop
    put(FUNC_ACK, ID_MATCH, 1'b0, 0);      // ack while idle: drop
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // tick while disarmed
    put(FUNC_UNUSED, ID_RAW, 1'b1, 1);     // unused func code
    put(FUNC_REQUEST, ID_RAW, 1'b0, 1);    // first id, reset flag, extreme setpoints
    put(FUNC_REQUEST, ID_RAW, 1'b0, 2);    // request while busy: drop
    put(FUNC_REPORT, ID_MATCH, 1'b0, 2);   // report before ack: drop
    put(FUNC_ACK, ID_NEAR, 1'b0, 0);       // ack with wrong id: drop
    put(FUNC_ACK, ID_MATCH, 1'b0, 0);
    put(FUNC_ARM, ID_RAW, 1'b0, 0);        // armed while waiting on a report
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // tick while busy
    put(FUNC_REPORT, ID_MATCH, 1'b0, 2);   // latch extreme values
    put(FUNC_TICK, ID_RAW, 1'b0, 0);       // partner not ready
    gen_now = 32'd1100;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // first stop goes at once
    gen_now = 32'd1199;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // one ms short of the interval
    gen_now = 32'd1200;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // exactly the interval
    gen_now = 32'd1300;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // last stop, sequence disarms
    put(FUNC_ARM, ID_RAW, 1'b0, 0);
    put(FUNC_CANCEL, ID_RAW, 1'b0, 0);
    put(FUNC_TICK, ID_RAW, 1'b1, 0);       // canceled: nothing
    put(FUNC_REQUEST, ID_RAW, 1'b0, 2);    // plain command
    put(FUNC_RESTART, ID_RAW, 1'b0, 0);    // drop the exchange, clear latches
    put(FUNC_REQUEST, ID_RAW, 1'b0, 0);    // ids start over
    put(FUNC_ACK, ID_MATCH, 1'b0, 0);
    put(FUNC_REPORT, ID_MATCH, 1'b0, 0);
    // leave two stops sent and the sequence armed across the register change
    put(FUNC_ARM, ID_RAW, 1'b0, 0);
    gen_now = 32'd5000;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);
    gen_now = 32'd5100;
    put(FUNC_TICK, ID_RAW, 1'b1, 0);
    drain();

    for (int chunk = 0; chunk < 11; chunk++) begin
      idle_on = (chunk % 4) != 2;
      case (chunk)
        0: begin
          // count lowered below the stops already sent: the next tick disarms
          set_regs(8'd1, 16'd100);
          put(FUNC_TICK, ID_RAW, 1'b1, 0);
        end
        1: set_regs(8'd255, 16'd65535);
        2: set_regs(8'd2, 16'd0);
        3: set_regs(StopSendMaxRst, StopIntervalRst);
        5: set_regs(8'd4, 16'd100);
        7: set_regs(8'd1, 16'd0);
        9: set_regs(8'd255, 16'd65535);
        default: set_regs(StopMaxW'($urandom_range(1, 255)),
                          IntervalW'($urandom_range(0, 300)));
      endcase
      random_chunk(110, 1'b1);
      drain();
    end

    // let any stray result show up before the verdict
    repeat (10) @(negedge clk);
    if (bad_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
